// ----- design/rkbd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rkbd_pkg
// Shared types and constants for the rolling-key byte decoder.
// ----------------------------------------------------------------------------
package rkbd_pkg;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned STEP_W  = 32;
    localparam int unsigned HIST_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // decode modes (codes 5..7 behave as pass)
    localparam logic [MODE_W-1:0] MODE_PASS = 3'd0;
    localparam logic [MODE_W-1:0] MODE_XOR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROL  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_KEY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK    = 2'd3;

    // xor group sizes
    localparam logic [2:0] GROUP_1 = 3'd1;
    localparam logic [2:0] GROUP_2 = 3'd2;
    localparam logic [2:0] GROUP_4 = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [KEY_W-1:0]         initial_key;
        logic signed [STEP_W-1:0] key_step;
        logic                     feedback_enable;
    } rkbd_cfg_t;

endpackage
`default_nettype wire

// ----- design/rkbd_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rkbd_cfg
// Configuration register file, one write transaction per cycle.
// ----------------------------------------------------------------------------
module rkbd_cfg
    import rkbd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [KEY_W-1:0]     cfg_data,
    output rkbd_cfg_t                 cfg
);

    rkbd_cfg_t cfg_reg;
    rkbd_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:        cfg_next.mode            = cfg_data[MODE_W-1:0];
                REG_INITIAL_KEY: cfg_next.initial_key     = cfg_data;
                REG_KEY_STEP:    cfg_next.key_step        = signed'(cfg_data[STEP_W-1:0]);
                REG_FEEDBACK:    cfg_next.feedback_enable = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode            <= MODE_XOR;
            cfg_reg.initial_key     <= '0;
            cfg_reg.key_step        <= '0;
            cfg_reg.feedback_enable <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/rkbd_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rkbd_core
// Byte decode and running-key state; state advances on each fire.
// ----------------------------------------------------------------------------
module rkbd_core
    import rkbd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              last_of_run,
    input  wire rkbd_cfg_t         cfg,
    output logic [BYTE_W-1:0]      out_byte
);

    logic [KEY_W-1:0]  key_reg,   key_next;
    logic              fresh_reg, fresh_next;
    logic [1:0]        lane_reg,  lane_next;
    logic [2:0]        gsize_reg, gsize_next;
    logic [HIST_W-1:0] hist_reg,  hist_next;

    logic [KEY_W-1:0]  key_cur;
    logic [1:0]        lane_cur;
    logic [2:0]        gsize_cur;
    logic [HIST_W-1:0] hist_cur;
    logic [2:0]        gsize_new;
    logic [1:0]        lane_inc;
    logic              group_done;
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] key_lane;
    logic [KEY_W-1:0]  step_ext;
    logic [KEY_W-1:0]  fb_word;

    always_comb begin
        // a run start behaves as if state had just been reloaded
        key_cur   = fresh_reg ? cfg.initial_key : key_reg;
        lane_cur  = fresh_reg ? 2'd0 : lane_reg;
        gsize_cur = fresh_reg ? GROUP_1 : gsize_reg;
        hist_cur  = fresh_reg ? '0 : hist_reg;

        if (|key_cur[KEY_W-1:24])
            gsize_new = GROUP_4;
        else if (|key_cur[KEY_W-1:8])
            gsize_new = GROUP_2;
        else
            gsize_new = GROUP_1;

        case (lane_cur)
            2'd0:    key_lane = key_cur[7:0];
            2'd1:    key_lane = key_cur[15:8];
            2'd2:    key_lane = key_cur[23:16];
            default: key_lane = key_cur[31:24];
        endcase

        lane_inc   = lane_cur + 2'd1;
        lane_next  = 2'd0;
        gsize_next = GROUP_1;
        group_done = 1'b1;

        case (cfg.mode)
            MODE_XOR: begin
                gsize_next = (lane_cur == 2'd0) ? gsize_new : gsize_cur;
                d          = in_byte ^ key_lane;
                group_done = (lane_inc == 2'd0) || ({1'b0, lane_inc} >= gsize_next);
                lane_next  = group_done ? 2'd0 : lane_inc;
            end
            MODE_SUB: d = in_byte - key_cur[7:0];
            MODE_ADD: d = in_byte + key_cur[7:0];
            MODE_ROL: d = BYTE_W'({in_byte, in_byte} >> (BYTE_W - key_cur[2:0]));
            default:  d = in_byte;
        endcase

        hist_next = {d, hist_cur[HIST_W-1:BYTE_W]};
        step_ext  = KEY_W'(cfg.key_step);
        fb_word   = cfg.feedback_enable ? KEY_W'(hist_next) : '0;
        key_next  = group_done ? (key_cur + step_ext + fb_word) : key_cur;
        fresh_next = last_of_run;
    end

    assign out_byte = d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            fresh_reg <= 1'b1;
            lane_reg  <= 2'd0;
            gsize_reg <= GROUP_1;
            hist_reg  <= '0;
        end else if (fire) begin
            key_reg   <= key_next;
            fresh_reg <= fresh_next;
            lane_reg  <= lane_next;
            gsize_reg <= gsize_next;
            hist_reg  <= hist_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/rolling_key_byte_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_key_byte_decoder
// Stream decoder: pass, xor (key groups of 4/2/1 bytes), subtract, add or
// rotate-left with a running key that steps after each group.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata[7:0] in_byte, tlast last_of_run
//  m_       | out       | m_tvalid/m_tready  | tdata[7:0] out_byte
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
//  One byte per cycle sustained while m_tready is high; a byte taken into the
//  input register moves on into the result register, with m_tvalid high, when
//  the result register is empty or its byte is being taken.
//  The running-key update (one 64-bit three-operand add) sits between the
//  input register and the key register and sets the clock limit.
//  aresetn is synchronous, active low; it empties both stages and loads the
//  register defaults (mode xor, zero key, zero step, no feedback).
//  A stalled result holds in the result register while the input register
//  still takes one more byte; cfg_ready is always high.
// ----------------------------------------------------------------------------
module rolling_key_byte_decoder
    import rkbd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] in_byte
    input  wire logic                 s_tlast,   // last_of_run
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [7:0] out_byte
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [KEY_W-1:0]     cfg_data
);

    rkbd_cfg_t cfg;

    // input register stage
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // result register stage
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;

    logic              s_accept;
    logic              advance;     // input stage moves into the result stage
    logic [BYTE_W-1:0] dec_byte;

    rkbd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // core state updates exactly once per byte, when it leaves the input stage; the key steps at group ends
    rkbd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (advance),
        .in_byte     (in_byte_reg),
        .last_of_run (in_last_reg),
        .cfg         (cfg),
        .out_byte    (dec_byte)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
            out_byte_reg <= dec_byte;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;

`ifndef SYNTH
    // a byte leaving the input stage always shows up as a result
    assert property (@(posedge aclk) disable iff (!aresetn) advance |=> m_tvalid)
        else $error("decoded byte did not reach the result register");

    // both stages empty right after reset
    assert property (@(posedge aclk) !aresetn |=> (!m_tvalid && !in_valid_reg))
        else $error("pipeline not empty after reset");

    // both stages full and result stalled: input side must hold off
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && in_valid_reg) |-> !s_tready)
        else $error("input accepted while both stages are full");

    // a result that is not taken stays valid and unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result lost");
`endif

endmodule
`default_nettype wire
